// ----- rtl/core/vss_pkg.sv -----
// shared types and constants of the vector similarity scorer
// used by vss_ctrl, vss_dp and vector_similarity_scorer; no dependencies
package vss_pkg;

    // metric codes of the metric configuration register
    localparam logic [2:0] METRIC_COSINE = 3'd0;
    localparam logic [2:0] METRIC_DOT    = 3'd1;
    localparam logic [2:0] METRIC_EUCL   = 3'd2;
    localparam logic [2:0] METRIC_MANH   = 3'd3;
    localparam logic [2:0] METRIC_JACC   = 3'd4;

    // configuration register indexes
    localparam logic [1:0] REG_METRIC = 2'd0;
    localparam logic [1:0] REG_PASS   = 2'd1;
    localparam logic [1:0] REG_WARN   = 2'd2;

    // reset values of the configuration registers
    localparam logic [2:0]  METRIC_RST = METRIC_COSINE;
    localparam logic [16:0] PASS_RST   = 17'd52429;
    localparam logic [16:0] WARN_RST   = 17'd32768;

    // one in q1.16 and the interpretation levels
    localparam logic [16:0] ONE_Q16   = 17'd65536;
    localparam logic [17:0] LVL_HIGH  = 18'sd58983;
    localparam logic [17:0] LVL_SIM   = 18'sd52429;
    localparam logic [17:0] LVL_SOME  = 18'sd39322;
    localparam logic [17:0] LVL_DIFF  = 18'sd19661;

    // interpretation codes
    localparam logic [2:0] INTERP_HIGH = 3'd0;
    localparam logic [2:0] INTERP_SIM  = 3'd1;
    localparam logic [2:0] INTERP_SOME = 3'd2;
    localparam logic [2:0] INTERP_DIFF = 3'd3;
    localparam logic [2:0] INTERP_VERY = 3'd4;

    // verdict codes
    localparam logic [1:0] VERDICT_PASS = 2'd0;
    localparam logic [1:0] VERDICT_WARN = 2'd1;
    localparam logic [1:0] VERDICT_FAIL = 2'd2;

    // iteration counts of the shared root and divide units
    localparam int SQ_STEPS  = 31;
    localparam int DIV_STEPS = 80;

    // root source select
    typedef enum logic [1:0] {
        SQ_NORM_A = 2'd0,
        SQ_NORM_B = 2'd1,
        SQ_DIFF   = 2'd2
    } vss_sq_sel_t;

    // commands from controller to datapath
    typedef struct packed {
        logic        take;
        logic        sq_start;
        vss_sq_sel_t sq_sel;
        logic        mul_en;
        logic        div_start;
        logic        fin_en;
    } vss_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic sq_done;
        logic div_done;
        logic out_busy;
    } vss_stat_t;

endpackage

// ----- rtl/core/vss_ctrl.sv -----
// sequencing state machine of the vector similarity scorer
// depends on vss_pkg for command and status types and metric codes
module vss_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               last_elem,
    input  logic [2:0]         metric,
    input  vss_pkg::vss_stat_t stat,
    output logic               in_stall,
    output vss_pkg::vss_cmd_t  cmd
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DRAIN  = 9'b000000010,
        S_DECIDE = 9'b000000100,
        S_SQA    = 9'b000001000,
        S_SQB    = 9'b000010000,
        S_SQE    = 9'b000100000,
        S_MUL    = 9'b001000000,
        S_DIV    = 9'b010000000,
        S_FIN    = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   fire;

    // input beats only while idle
    assign in_stall = (state_reg != S_IDLE);
    assign fire     = in_valid && !in_stall;

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.take      = fire;
        cmd.sq_sel    = vss_pkg::SQ_NORM_A;
        case (state_reg)
            S_IDLE:
            begin
                if (fire && last_elem)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                case (metric)
                    vss_pkg::METRIC_DOT:
                    begin
                        state_next = S_FIN;
                    end
                    vss_pkg::METRIC_EUCL:
                    begin
                        cmd.sq_start = 1'b1;
                        cmd.sq_sel   = vss_pkg::SQ_DIFF;
                        state_next   = S_SQE;
                    end
                    vss_pkg::METRIC_MANH, vss_pkg::METRIC_JACC:
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                    default:
                    begin
                        cmd.sq_start = 1'b1;
                        cmd.sq_sel   = vss_pkg::SQ_NORM_A;
                        state_next   = S_SQA;
                    end
                endcase
            end
            S_SQA:
            begin
                if (stat.sq_done)
                begin
                    cmd.sq_start = 1'b1;
                    cmd.sq_sel   = vss_pkg::SQ_NORM_B;
                    state_next   = S_SQB;
                end
            end
            S_SQB:
            begin
                if (stat.sq_done)
                begin
                    state_next = S_MUL;
                end
            end
            S_SQE:
            begin
                if (stat.sq_done)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_MUL:
            begin
                cmd.mul_en    = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!stat.out_busy)
                begin
                    cmd.fin_en = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // the multiply state also starts the divide, in the cycle after it
    // (divide operands read the product register, so start from S_MUL's successor)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTH
    // final beat leads straight into the drain cycle
    a_last_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && last_elem) |=> (state_reg == S_DRAIN))
        else $error("last beat did not start drain");

    // root and divide never start together
    a_one_start: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.sq_start && cmd.div_start))
        else $error("root and divide started together");

    // a root result arrives only while one is awaited
    a_sq_wait: assert property (@(posedge clk) disable iff (!rst_n)
        stat.sq_done |-> (state_reg == S_SQA || state_reg == S_SQB || state_reg == S_SQE))
        else $error("unexpected root done");

    // a result is loaded only when the output register is free
    a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin_en |-> !stat.out_busy)
        else $error("result loaded over a stalled beat");
`endif

endmodule

// ----- rtl/core/vss_dp.sv -----
// datapath of the vector similarity scorer: product stage, accumulators,
// shared bit-serial root and divide units, score and output register; uses vss_pkg
module vss_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  vss_pkg::vss_cmd_t  cmd,
    input  logic [2:0]         metric,
    input  logic [16:0]        pass_th,
    input  logic [16:0]        warn_th,
    input  logic signed [15:0] elem_a,
    input  logic signed [15:0] elem_b,
    input  logic               out_stall,
    output vss_pkg::vss_stat_t stat,
    output logic               out_valid,
    output logic signed [17:0] score,
    output logic [2:0]         interpretation,
    output logic [1:0]         verdict
);

    // product stage
    logic signed [31:0] ab_reg;
    logic [30:0]        aa_reg;
    logic [30:0]        bb_reg;
    logic [31:0]        dd_reg;
    logic [15:0]        ad_reg;
    logic [14:0]        pmin_reg;
    logic [14:0]        pmax_reg;
    logic               pv_reg;

    logic signed [31:0] ab;
    logic signed [31:0] aa;
    logic signed [31:0] bb;
    logic signed [16:0] d;
    logic [15:0]        ad;
    logic [14:0]        pa;
    logic [14:0]        pb;

    assign ab = elem_a * elem_b;
    assign aa = elem_a * elem_a;
    assign bb = elem_b * elem_b;
    assign d  = 17'(elem_a) - 17'(elem_b);
    assign ad = d[16] ? 16'(-d) : d[15:0];
    assign pa = elem_a[15] ? 15'd0 : elem_a[14:0];
    assign pb = elem_b[15] ? 15'd0 : elem_b[14:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
        end
        else
        begin
            pv_reg <= cmd.take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            ab_reg   <= ab;
            aa_reg   <= aa[30:0];
            bb_reg   <= bb[30:0];
            dd_reg   <= 32'(ad * ad);
            ad_reg   <= ad;
            pmin_reg <= (pa < pb) ? pa : pb;
            pmax_reg <= (pa > pb) ? pa : pb;
        end
    end

    // saturating accumulators
    logic signed [47:0] dot_reg;
    logic [47:0]        na_reg;
    logic [47:0]        nb_reg;
    logic [47:0]        sq_reg;
    logic [31:0]        abs_reg;
    logic [31:0]        min_reg;
    logic [31:0]        max_reg;

    logic signed [48:0] dot_sum;
    logic [48:0]        na_sum;
    logic [48:0]        nb_sum;
    logic [48:0]        sq_sum;
    logic [32:0]        abs_sum;
    logic [32:0]        min_sum;
    logic [32:0]        max_sum;

    assign dot_sum = 49'(dot_reg) + 49'(ab_reg);
    assign na_sum  = {1'b0, na_reg} + 49'(aa_reg);
    assign nb_sum  = {1'b0, nb_reg} + 49'(bb_reg);
    assign sq_sum  = {1'b0, sq_reg} + 49'(dd_reg);
    assign abs_sum = {1'b0, abs_reg} + 33'(ad_reg);
    assign min_sum = {1'b0, min_reg} + 33'(pmin_reg);
    assign max_sum = {1'b0, max_reg} + 33'(pmax_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg <= '0;
            na_reg  <= '0;
            nb_reg  <= '0;
            sq_reg  <= '0;
            abs_reg <= '0;
            min_reg <= '0;
            max_reg <= '0;
        end
        else if (cmd.fin_en)
        begin
            dot_reg <= '0;
            na_reg  <= '0;
            nb_reg  <= '0;
            sq_reg  <= '0;
            abs_reg <= '0;
            min_reg <= '0;
            max_reg <= '0;
        end
        else if (pv_reg)
        begin
            if (dot_sum[48] != dot_sum[47])
            begin
                dot_reg <= dot_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
            end
            else
            begin
                dot_reg <= dot_sum[47:0];
            end
            na_reg  <= na_sum[48]  ? '1 : na_sum[47:0];
            nb_reg  <= nb_sum[48]  ? '1 : nb_sum[47:0];
            sq_reg  <= sq_sum[48]  ? '1 : sq_sum[47:0];
            abs_reg <= abs_sum[32] ? '1 : abs_sum[31:0];
            min_reg <= min_sum[32] ? '1 : min_sum[31:0];
            max_reg <= max_sum[32] ? '1 : max_sum[31:0];
        end
    end

    // bit-serial integer root, two radicand bits per step
    logic [61:0]          sq_x_reg;
    logic [31:0]          sq_rem_reg;
    logic [30:0]          sq_root_reg;
    logic [4:0]           sq_cnt_reg;
    logic                 sq_busy_reg;
    logic                 sq_done_reg;
    vss_pkg::vss_sq_sel_t sq_sel_reg;
    logic [30:0]          ra_reg;
    logic [30:0]          rb_reg;

    logic [33:0] sq_rem_sh;
    logic [33:0] sq_trial;
    logic        sq_ge;
    logic [47:0] sq_src;

    assign sq_rem_sh = {sq_rem_reg, sq_x_reg[61:60]};
    assign sq_trial  = {1'b0, sq_root_reg, 2'b01};
    assign sq_ge     = (sq_rem_sh >= sq_trial);

    always_comb
    begin
        case (cmd.sq_sel)
            vss_pkg::SQ_NORM_A: sq_src = na_reg;
            vss_pkg::SQ_NORM_B: sq_src = nb_reg;
            vss_pkg::SQ_DIFF:   sq_src = sq_reg;
            default:            sq_src = sq_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_busy_reg <= 1'b0;
            sq_done_reg <= 1'b0;
            sq_cnt_reg  <= '0;
        end
        else
        begin
            sq_done_reg <= 1'b0;
            if (cmd.sq_start)
            begin
                sq_busy_reg <= 1'b1;
                sq_cnt_reg  <= '0;
            end
            else if (sq_busy_reg)
            begin
                sq_cnt_reg <= sq_cnt_reg + 5'd1;
                if (sq_cnt_reg == 5'(vss_pkg::SQ_STEPS - 1))
                begin
                    sq_busy_reg <= 1'b0;
                    sq_done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sq_start)
        begin
            sq_x_reg    <= {sq_src, 14'd0};
            sq_rem_reg  <= '0;
            sq_root_reg <= '0;
            sq_sel_reg  <= cmd.sq_sel;
        end
        else if (sq_busy_reg)
        begin
            sq_x_reg <= {sq_x_reg[59:0], 2'b00};
            if (sq_ge)
            begin
                sq_rem_reg  <= 32'(sq_rem_sh - sq_trial);
                sq_root_reg <= {sq_root_reg[29:0], 1'b1};
            end
            else
            begin
                sq_rem_reg  <= sq_rem_sh[31:0];
                sq_root_reg <= {sq_root_reg[29:0], 1'b0};
            end
        end
        // park each finished norm root; the difference root feeds the divider directly
        if (sq_done_reg)
        begin
            case (sq_sel_reg)
                vss_pkg::SQ_NORM_A: ra_reg <= sq_root_reg;
                vss_pkg::SQ_NORM_B: rb_reg <= sq_root_reg;
                default:            ;
            endcase
        end
    end

    // norm product for cosine
    logic [61:0] p_reg;
    logic        div_go_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            p_reg <= 62'(ra_reg * rb_reg);
        end
    end

    // divide starts on the start command, or for cosine in the cycle after the product is taken
    logic div_go;

    assign div_go = (cmd.div_start && (metric != vss_pkg::METRIC_COSINE) &&
                     (metric != vss_pkg::METRIC_DOT) && (metric <= vss_pkg::METRIC_JACC))
                    || div_go_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_go_reg <= 1'b0;
        end
        else
        begin
            div_go_reg <= cmd.mul_en;
        end
    end

    // dot magnitude and sign
    logic        neg;
    logic [47:0] mag;

    assign neg = dot_reg[47];
    assign mag = neg ? 48'(-dot_reg) : dot_reg;

    // restoring divide of a shifted dividend, quotient capped at one
    logic [79:0] dv_dvd_reg;
    logic [61:0] dv_rem_reg;
    logic [61:0] dv_den_reg;
    logic [16:0] dv_q_reg;
    logic        dv_sat_reg;
    logic [6:0]  dv_cnt_reg;
    logic        dv_busy_reg;
    logic        dv_done_reg;

    logic [62:0] dv_rem_sh;
    logic        dv_ge;
    logic [17:0] dv_qn;
    logic [79:0] dvd_src;
    logic [61:0] den_src;

    assign dv_rem_sh = {dv_rem_reg, dv_dvd_reg[79]};
    assign dv_ge     = (dv_rem_sh >= {1'b0, dv_den_reg});
    assign dv_qn     = {dv_q_reg, dv_ge};

    always_comb
    begin
        case (metric)
            vss_pkg::METRIC_EUCL:
            begin
                // root is still held in the root unit when the divide starts
                dvd_src = 80'(1) << 38;
                den_src = (62'(1) << 22) + 62'(sq_root_reg);
            end
            vss_pkg::METRIC_MANH:
            begin
                dvd_src = 80'(1) << 31;
                den_src = (62'(1) << 15) + 62'(abs_reg);
            end
            vss_pkg::METRIC_JACC:
            begin
                dvd_src = 80'(min_reg) << 16;
                den_src = 62'(max_reg);
            end
            default:
            begin
                dvd_src = 80'(mag) << 30;
                den_src = p_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_busy_reg <= 1'b0;
            dv_done_reg <= 1'b0;
            dv_cnt_reg  <= '0;
        end
        else
        begin
            dv_done_reg <= 1'b0;
            if (div_go)
            begin
                dv_busy_reg <= 1'b1;
                dv_cnt_reg  <= '0;
            end
            else if (dv_busy_reg)
            begin
                dv_cnt_reg <= dv_cnt_reg + 7'd1;
                if (dv_cnt_reg == 7'(vss_pkg::DIV_STEPS - 1))
                begin
                    dv_busy_reg <= 1'b0;
                    dv_done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_go)
        begin
            dv_dvd_reg <= dvd_src;
            dv_den_reg <= den_src;
            dv_rem_reg <= '0;
            dv_q_reg   <= '0;
            dv_sat_reg <= 1'b0;
        end
        else if (dv_busy_reg)
        begin
            dv_dvd_reg <= {dv_dvd_reg[78:0], 1'b0};
            dv_rem_reg <= dv_ge ? 62'(dv_rem_sh - {1'b0, dv_den_reg}) : dv_rem_sh[61:0];
            dv_q_reg   <= dv_qn[16:0];
            dv_sat_reg <= dv_sat_reg || (dv_qn > 18'(vss_pkg::ONE_Q16));
        end
    end

    // score selection
    logic [16:0]        q_fin;
    logic [16:0]        dot_q;
    logic [16:0]        sel_mag;
    logic               sel_neg;
    logic signed [17:0] score_c;
    logic signed [18:0] score_w;
    logic [2:0]         interp_c;
    logic [1:0]         verdict_c;

    assign q_fin = dv_sat_reg ? vss_pkg::ONE_Q16 : dv_q_reg;
    assign dot_q = (mag[47:14] > 34'(vss_pkg::ONE_Q16)) ? vss_pkg::ONE_Q16 : mag[30:14];

    always_comb
    begin
        sel_neg = 1'b0;
        case (metric)
            vss_pkg::METRIC_DOT:
            begin
                sel_mag = dot_q;
                sel_neg = neg;
            end
            vss_pkg::METRIC_EUCL, vss_pkg::METRIC_MANH:
            begin
                sel_mag = q_fin;
            end
            vss_pkg::METRIC_JACC:
            begin
                sel_mag = (max_reg == '0) ? vss_pkg::ONE_Q16 : q_fin;
            end
            default:
            begin
                sel_mag = (p_reg == '0) ? 17'd0 : q_fin;
                sel_neg = neg;
            end
        endcase
    end

    assign score_c = sel_neg ? -$signed({1'b0, sel_mag}) : $signed({1'b0, sel_mag});
    assign score_w = 19'(score_c);

    // interpretation and verdict
    always_comb
    begin
        if (score_c >= $signed(vss_pkg::LVL_HIGH))
        begin
            interp_c = vss_pkg::INTERP_HIGH;
        end
        else if (score_c >= $signed(vss_pkg::LVL_SIM))
        begin
            interp_c = vss_pkg::INTERP_SIM;
        end
        else if (score_c >= $signed(vss_pkg::LVL_SOME))
        begin
            interp_c = vss_pkg::INTERP_SOME;
        end
        else if (score_c >= $signed(vss_pkg::LVL_DIFF))
        begin
            interp_c = vss_pkg::INTERP_DIFF;
        end
        else
        begin
            interp_c = vss_pkg::INTERP_VERY;
        end

        if (score_w >= $signed({2'b00, pass_th}))
        begin
            verdict_c = vss_pkg::VERDICT_PASS;
        end
        else if (score_w >= $signed({2'b00, warn_th}))
        begin
            verdict_c = vss_pkg::VERDICT_WARN;
        end
        else
        begin
            verdict_c = vss_pkg::VERDICT_FAIL;
        end
    end

    // output register
    logic               out_valid_reg;
    logic signed [17:0] score_reg;
    logic [2:0]         interp_reg;
    logic [1:0]         verdict_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.fin_en)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin_en)
        begin
            score_reg   <= score_c;
            interp_reg  <= interp_c;
            verdict_reg <= verdict_c;
        end
    end

    assign out_valid      = out_valid_reg;
    assign score          = score_reg;
    assign interpretation = interp_reg;
    assign verdict        = verdict_reg;

    assign stat.sq_done  = sq_done_reg;
    assign stat.div_done = dv_done_reg;
    assign stat.out_busy = out_valid_reg && out_stall;

`ifndef SYNTH
    // root and divide units never run at once
    a_units_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(sq_busy_reg && dv_busy_reg))
        else $error("root and divide busy together");

    // accumulators are clear right after a result is loaded
    a_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin_en |=> (dot_reg == '0 && max_reg == '0 && na_reg == '0))
        else $error("accumulators not cleared");

    // a loaded result stays unchanged while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(score_reg)))
        else $error("stalled result changed");
`endif

endmodule

// ----- rtl/core/vector_similarity_scorer.sv -----
// vector similarity scorer: one element pair per beat, result after the last beat
// (31-step root, 80-step divide): dot product needs neither, manhattan and jaccard
// use the divide, euclidean a root then the divide, cosine two roots, product, divide
// throughput: one pair per cycle while accumulating; no new pair until the score is loaded
// reset: asynchronous active low, clears accumulators, control, config registers and valid flags
// depends on vss_pkg, vss_ctrl and vss_dp
module vector_similarity_scorer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [16:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] elem_a,
    input  logic signed [15:0] elem_b,
    input  logic               last_elem,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [17:0] score,
    output logic [2:0]         interpretation,
    output logic [1:0]         verdict
);

    logic [2:0]         metric_reg;
    logic [16:0]        pass_reg;
    logic [16:0]        warn_reg;
    vss_pkg::vss_cmd_t  cmd;
    vss_pkg::vss_stat_t stat;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            metric_reg <= vss_pkg::METRIC_RST;
            pass_reg   <= vss_pkg::PASS_RST;
            warn_reg   <= vss_pkg::WARN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                vss_pkg::REG_METRIC: metric_reg <= cfg_data[2:0];
                vss_pkg::REG_PASS:   pass_reg   <= cfg_data;
                vss_pkg::REG_WARN:   warn_reg   <= cfg_data;
                default:             ;
            endcase
        end
    end

    // sequencer
    vss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last_elem (last_elem),
        .metric    (metric_reg),
        .stat      (stat),
        .in_stall  (in_stall),
        .cmd       (cmd)
    );

    // datapath
    vss_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .metric         (metric_reg),
        .pass_th        (pass_reg),
        .warn_th        (warn_reg),
        .elem_a         (elem_a),
        .elem_b         (elem_b),
        .out_stall      (out_stall),
        .stat           (stat),
        .out_valid      (out_valid),
        .score          (score),
        .interpretation (interpretation),
        .verdict        (verdict)
    );

endmodule

// ----- test/vss_checker.sv -----
// scoreboard for the vector similarity scorer: watches config writes and both beat channels,
// predicts each score from the accumulated element pairs and compares field by field
// depends on vss_pkg
module vss_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [16:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [15:0] elem_a,
    input  logic signed [15:0] elem_b,
    input  logic               last_elem,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [17:0] score,
    input  logic [2:0]         interpretation,
    input  logic [1:0]         verdict,
    output int                 err_count,
    output int                 pending
);

    typedef struct packed {
        logic signed [17:0] score;
        logic [2:0]         interp;
        logic [1:0]         verdict;
    } score_rec_t;

    localparam longint          DOT_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint          DOT_LO = -64'sh0000_8000_0000_0000;
    localparam longint unsigned LIM48  = 64'h0000_FFFF_FFFF_FFFF;
    localparam longint unsigned LIM32  = 64'h0000_0000_FFFF_FFFF;

    score_rec_t      score_q[$];
    logic [2:0]      metric_r;
    logic [16:0]     pass_r;
    logic [16:0]     warn_r;
    longint          dot_sum;
    longint unsigned na_sum, nb_sum, sqd_sum, absd_sum, min_sum, max_sum;

    assign pending = score_q.size();

    function automatic longint unsigned clip_add(input longint unsigned acc,
                                                 input longint unsigned v,
                                                 input longint unsigned lim);
        longint unsigned s;
        s = acc + v;
        return (s > lim) ? lim : s;
    endfunction

    function automatic longint unsigned int_root(input longint unsigned x);
        longint unsigned r, bit_v;
        r = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > x) bit_v = bit_v >> 2;
        while (bit_v != 0)
        begin
            if (x >= r + bit_v)
            begin
                x = x - (r + bit_v);
                r = (r >> 1) + bit_v;
            end
            else
                r = r >> 1;
            bit_v = bit_v >> 2;
        end
        return r;
    endfunction

    // floor(num * 2^f / den) with an early cap
    function automatic longint unsigned scaled_quot(input longint unsigned num,
                                                    input longint unsigned den,
                                                    input int f,
                                                    input longint unsigned cap);
        longint unsigned q, r;
        q = num / den;
        r = num % den;
        if (q > cap) return cap;
        for (int i = 0; i < f; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= den)
            begin
                r = r - den;
                q = q | 64'd1;
            end
            if (q > cap) return cap;
        end
        return q;
    endfunction

    function automatic longint score_of();
        logic            neg;
        longint unsigned mag, p, cap;
        longint          sc;
        neg = dot_sum < 0;
        mag = neg ? longint'(-dot_sum) : longint'(dot_sum);
        cap = longint'(vss_pkg::ONE_Q16);
        case (metric_r)
            vss_pkg::METRIC_DOT:
            begin
                mag = mag >> 14;
                if (mag > cap) mag = cap;
                sc = neg ? -longint'(mag) : longint'(mag);
            end
            vss_pkg::METRIC_EUCL:
                sc = longint'((64'd1 << 38) / ((64'd1 << 22) + int_root(sqd_sum << 14)));
            vss_pkg::METRIC_MANH:
                sc = longint'((64'd1 << 31) / ((64'd1 << 15) + absd_sum));
            vss_pkg::METRIC_JACC:
                if (max_sum == 0) sc = longint'(vss_pkg::ONE_Q16);
                else sc = longint'(scaled_quot(min_sum, max_sum, 16, cap));
            default:
            begin
                // zero norm gives zero; unused codes fall here too
                p = int_root(na_sum << 14) * int_root(nb_sum << 14);
                if (p == 0) sc = 0;
                else
                begin
                    mag = scaled_quot(mag, p, 30, cap);
                    sc = neg ? -longint'(mag) : longint'(mag);
                end
            end
        endcase
        return sc;
    endfunction

    // accumulate one pair, queue a score on the last one
    task automatic take_pair();
        longint          a, b, d, s, sc;
        longint unsigned ad, pa, pb;
        score_rec_t      rec;
        a = longint'(elem_a);
        b = longint'(elem_b);
        d = a - b;
        ad = (d < 0) ? -d : d;
        pa = (a > 0) ? a : 0;
        pb = (b > 0) ? b : 0;
        s = dot_sum + a * b;
        dot_sum = (s > DOT_HI) ? DOT_HI : (s < DOT_LO) ? DOT_LO : s;
        na_sum = clip_add(na_sum, a * a, LIM48);
        nb_sum = clip_add(nb_sum, b * b, LIM48);
        sqd_sum = clip_add(sqd_sum, ad * ad, LIM48);
        absd_sum = clip_add(absd_sum, ad, LIM32);
        min_sum = clip_add(min_sum, (pa < pb) ? pa : pb, LIM32);
        max_sum = clip_add(max_sum, (pa > pb) ? pa : pb, LIM32);
        if (last_elem)
        begin
            sc = score_of();
            rec.score = sc[17:0];
            if (sc >= longint'(vss_pkg::LVL_HIGH)) rec.interp = vss_pkg::INTERP_HIGH;
            else if (sc >= longint'(vss_pkg::LVL_SIM)) rec.interp = vss_pkg::INTERP_SIM;
            else if (sc >= longint'(vss_pkg::LVL_SOME)) rec.interp = vss_pkg::INTERP_SOME;
            else if (sc >= longint'(vss_pkg::LVL_DIFF)) rec.interp = vss_pkg::INTERP_DIFF;
            else rec.interp = vss_pkg::INTERP_VERY;
            if (sc >= longint'(pass_r)) rec.verdict = vss_pkg::VERDICT_PASS;
            else if (sc >= longint'(warn_r)) rec.verdict = vss_pkg::VERDICT_WARN;
            else rec.verdict = vss_pkg::VERDICT_FAIL;
            score_q.insert(score_q.size(), rec);
            dot_sum = 0;
            na_sum = 0; nb_sum = 0; sqd_sum = 0;
            absd_sum = 0; min_sum = 0; max_sum = 0;
        end
    endtask

    // register copy, predictor and compare
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            metric_r = vss_pkg::METRIC_RST;
            pass_r = vss_pkg::PASS_RST;
            warn_r = vss_pkg::WARN_RST;
            dot_sum = 0;
            na_sum = 0; nb_sum = 0; sqd_sum = 0;
            absd_sum = 0; min_sum = 0; max_sum = 0;
            err_count = 0;
            score_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == vss_pkg::REG_METRIC) metric_r = cfg_data[2:0];
                else if (cfg_index == vss_pkg::REG_PASS) pass_r = cfg_data;
                else if (cfg_index == vss_pkg::REG_WARN) warn_r = cfg_data;
            end
            if (in_valid && !in_stall) take_pair();
            if (out_valid && !out_stall)
            begin
                if (score_q.size() == 0)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("unexpected result beat: score %0d interp %0d verdict %0d",
                                 score, interpretation, verdict);
                end
                else
                begin
                    score_rec_t want;
                    want = score_q.pop_front();
                    if (want.score !== score || want.interp !== interpretation ||
                        want.verdict !== verdict)
                    begin
                        err_count++;
                        if (err_count <= 10)
                            $display("mismatch: exp score %0d interp %0d verdict %0d, got %0d %0d %0d",
                                     want.score, want.interp, want.verdict,
                                     score, interpretation, verdict);
                    end
                end
            end
        end
    end

endmodule

// ----- test/vector_similarity_scorer_tb.sv -----
// top of the vector similarity scorer testbench: clock, reset, element pair stimulus,
// register writes and final verdict; depends on vss_pkg, vss_checker and the scorer
module vector_similarity_scorer_tb;

    localparam int         CYCLE_LIMIT = 1000000;
    localparam int         DRAIN_WAIT  = 200;
    localparam logic [1:0] REG_UNUSED  = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [16:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] elem_a;
    logic signed [15:0] elem_b;
    logic               last_elem;
    logic               out_valid;
    logic               out_stall;
    logic signed [17:0] score;
    logic [2:0]         interpretation;
    logic [1:0]         verdict;
    int                 err_count;
    int                 pending;
    int                 cycles;
    int                 in_idle;
    int                 out_idle;

    vector_similarity_scorer dut (.*);

    vss_checker chk (.*);

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver stall
    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < out_idle);

    // cycle watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("vector_similarity_scorer_tb: done, errors");
            $finish;
        end
    end

    // one pair beat, with random gaps in front
    task automatic send_pair(input logic signed [15:0] a, input logic signed [15:0] b,
                             input logic lst);
        while ($urandom_range(0, 99) < in_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        elem_a <= a;
        elem_b <= b;
        last_elem <= lst;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    // register write once every score is out
    task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // one vector of random shape and the given length
    task automatic send_vector(input int len);
        int                 mode;
        logic signed [15:0] a, b;
        mode = $urandom_range(0, 9);
        for (int i = 0; i < len; i++)
        begin
            a = 16'($urandom);
            case (mode)
                1: b = a;
                2: b = -a;
                3: begin a = 0; b = 16'($urandom); end
                4: b = a + $signed(16'($urandom_range(0, 64))) - 16'sd32;
                5:
                begin
                    a = 16'($urandom_range(0, 32767));
                    b = 16'($urandom_range(0, 32767));
                end
                6: begin a = 0; b = 0; end
                default: b = 16'($urandom);
            endcase
            send_pair(a, b, i == len - 1);
        end
    endtask

    function automatic logic [16:0] pick_threshold();
        case ($urandom_range(0, 5))
            0: return 17'd0;
            1: return vss_pkg::ONE_Q16;
            2: return 17'h1FFFF;
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    initial
    begin
        int sent;
        int ph;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        elem_a = '0;
        elem_b = '0;
        last_elem = 1'b0;
        out_stall = 1'b0;
        cycles = 0;
        in_idle = 36;
        out_idle = 36;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, zero vector, identical and opposite, reset thresholds
        send_pair(16'sh7FFF, 16'sh7FFF, 1'b1);
        send_pair(-16'sh8000, 16'sh7FFF, 1'b1);
        send_pair(16'sh0000, 16'sh0000, 1'b1);
        send_pair(16'sh0000, 16'sh4000, 1'b1);
        send_pair(-16'sh8000, -16'sh8000, 1'b0);
        send_pair(16'sh7FFF, -16'sh8000, 1'b1);
        for (int m = 0; m < 8; m++)
        begin
            write_reg(vss_pkg::REG_METRIC, 17'(m));
            send_pair(16'sh1234, 16'sh1200, 1'b0);
            send_pair(-16'sh8000, 16'sh7FFF, 1'b1);
            send_pair(16'sh0000, 16'sh0000, 1'b1);
        end
        write_reg(REG_UNUSED, 17'h1FFFF);

        // random phases, each under its own register setting
        sent = 0;
        ph = 0;
        while (sent < 1300)
        begin
            if (ph >= 3 && ph <= 5)
            begin
                in_idle = 0;
                out_idle = 0;
            end
            else
            begin
                in_idle = 36;
                out_idle = 36;
            end
            write_reg(vss_pkg::REG_METRIC, (ph < 8) ? 17'(ph) : 17'($urandom_range(0, 7)));
            write_reg(vss_pkg::REG_PASS, pick_threshold());
            write_reg(vss_pkg::REG_WARN, pick_threshold());
            for (int v = 0; v < 12; v++)
            begin
                int len;
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                  : $urandom_range(1, 8);
                send_vector(len);
                sent += len;
            end
            ph++;
        end
        in_valid <= 1'b0;

        // drain
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
        if (err_count == 0 && pending == 0)
            $display("vector_similarity_scorer_tb: done, clean");
        else
            $display("vector_similarity_scorer_tb: done, errors");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/vss_pkg.sv
rtl/core/vss_ctrl.sv
rtl/core/vss_dp.sv
rtl/core/vector_similarity_scorer.sv
test/vss_checker.sv
test/vector_similarity_scorer_tb.sv
